// ===== sv/aap_pkg.sv =====
`default_nettype none

package aap_pkg;

  localparam int SAMPLE_W          = 12;
  localparam int PCT_W             = 8;
  localparam int PROD_W            = 19;
  localparam int BUF_DEPTH_DEFAULT = 16;
  localparam int CALIB_FACTOR      = 10;
  localparam int SCALE             = 100;
  localparam int PCT_MAX           = 250;
  localparam int PCT_MIN           = 5;

  localparam logic [SAMPLE_W-1:0] SWING_RESET = 12'd800;

endpackage

`default_nettype wire

// ===== sv/aap_ram.sv =====
`default_nettype none

module aap_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/aap_serdiv.sv =====
`default_nettype none

// Restoring divider: one quotient bit per cycle, MSB first.
module aap_serdiv #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W+1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {1'b0, rem_r, acc_r[NUM_W-1]} - {2'b00, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // A clear top bit means the shifted remainder was at least the divisor.
      if (!trial[DEN_W+1]) begin
        rem_nxt = trial[DEN_W-1:0];
        acc_nxt = {acc_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DEN_W-2:0], acc_r[NUM_W-1]};
        acc_nxt = {acc_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = acc_r;

endmodule

`default_nettype wire

// ===== sv/altitude_average_percent_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_sample[11:0]
// out_      output     out_valid/out_stall  out_altitude_percent[7:0]
// cfg_      input      cfg_valid/cfg_ready  cfg_full_swing[11:0]
//
// A calibration sample passes through a ring read, then the sum and reference update.
// A measuring sample goes on to the mean, the scaling and the serial divider for the
// percentage; a depth that is not a power of two also takes the mean from the same
// divider. NUM_W is the larger of 19 and 12 + ceil(log2(depth)).
// Reset is synchronous and needs no clearing pass; ring data is only used once written.
// The output register lets the next request in while a result is stalled.
module altitude_average_percent_unit #(
  parameter int BUF_DEPTH = aap_pkg::BUF_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [aap_pkg::SAMPLE_W-1:0] in_sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [aap_pkg::PCT_W-1:0]    out_altitude_percent,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [aap_pkg::SAMPLE_W-1:0] cfg_full_swing
);

  localparam int SW      = aap_pkg::SAMPLE_W;
  localparam int PW      = aap_pkg::PCT_W;
  localparam int PTR_W   = $clog2(BUF_DEPTH);
  localparam int SUM_W   = SW + PTR_W;
  localparam int CALIB   = aap_pkg::CALIB_FACTOR * BUF_DEPTH + 1;
  localparam int CNT_W   = $clog2(CALIB + 1);
  localparam int NUM_W   = (SUM_W > aap_pkg::PROD_W) ? SUM_W : aap_pkg::PROD_W;
  localparam bit IS_POW2 = (BUF_DEPTH & (BUF_DEPTH - 1)) == 0;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(BUF_DEPTH / 2);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_UPD       = 7'b0000010,
    ST_MEAN      = 7'b0000100,
    ST_MEAN_WAIT = 7'b0001000,
    ST_SCALE     = 7'b0010000,
    ST_PCT_WAIT  = 7'b0100000,
    ST_PUSH      = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    sample_r, sample_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [PTR_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] calib_cnt_r, calib_cnt_nxt;
  logic [SW-1:0]    ref_r, ref_nxt;
  logic             calibrated_r, calibrated_nxt;
  logic [SW-1:0]    swing_r, swing_nxt;
  logic [SW-1:0]    mean_r, mean_nxt;
  logic [PW-1:0]    pct_r, pct_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PW-1:0]    out_pct_r, out_pct_nxt;

  logic             in_accept;
  logic [SW-1:0]    ring_rd;
  logic             ring_we;
  logic [SW-1:0]    sub_val;
  logic [CNT_W-1:0] cnt_inc;
  logic [SUM_W-1:0] sum_round;
  logic [SUM_W-1:0] mean_shift;
  logic [SW-1:0]    diff;
  logic [aap_pkg::PROD_W-1:0] prod;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [SW-1:0]    div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  aap_ram #(
    .WIDTH (SW),
    .DEPTH (BUF_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (pos_r),
    .wr_data (sample_r),
    .rd_en   (in_accept),
    .rd_addr (pos_r),
    .rd_data (ring_rd)
  );

  aap_serdiv #(
    .NUM_W (NUM_W),
    .DEN_W (SW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    sub_val    = (calib_cnt_r >= CNT_W'(BUF_DEPTH)) ? ring_rd : '0;
    cnt_inc    = calib_cnt_r + 1'b1;
    sum_round  = sum_r + HALF;
    mean_shift = sum_round >> PTR_W;
    diff       = ref_r - mean_r;
    prod       = aap_pkg::PROD_W'(diff) * aap_pkg::PROD_W'(aap_pkg::SCALE);
  end

  always_comb begin
    state_nxt      = state_r;
    sample_nxt     = sample_r;
    sum_nxt        = sum_r;
    pos_nxt        = pos_r;
    calib_cnt_nxt  = calib_cnt_r;
    ref_nxt        = ref_r;
    calibrated_nxt = calibrated_r;
    mean_nxt       = mean_r;
    pct_nxt        = pct_r;
    out_valid_nxt  = out_valid_r;
    out_pct_nxt    = out_pct_r;
    ring_we        = 1'b0;
    div_start      = 1'b0;
    div_num        = NUM_W'(sum_round);
    div_den        = SW'(BUF_DEPTH);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      swing_nxt = cfg_full_swing;
    end else begin
      swing_nxt = swing_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          sample_nxt = in_sample;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        ring_we = 1'b1;
        sum_nxt = sum_r - SUM_W'(sub_val) + SUM_W'(sample_r);
        pos_nxt = (pos_r == PTR_W'(BUF_DEPTH - 1)) ? '0 : pos_r + 1'b1;
        if (!calibrated_r) begin
          if (sample_r > ref_r) begin
            ref_nxt = sample_r;
          end
          calib_cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_W'(CALIB)) begin
            calibrated_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (IS_POW2) begin
          mean_nxt  = SW'(mean_shift);
          state_nxt = ST_SCALE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_MEAN_WAIT;
        end
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean_nxt  = SW'(div_quo);
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        div_num = NUM_W'(prod);
        div_den = swing_r;
        // A mean above the reference or a zero swing gives no valid percentage.
        if (swing_r == '0 || mean_r > ref_r) begin
          pct_nxt   = '0;
          state_nxt = ST_PUSH;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_PCT_WAIT;
        end
      end
      ST_PCT_WAIT: begin
        if (div_done) begin
          if (div_quo > NUM_W'(aap_pkg::PCT_MAX) || div_quo < NUM_W'(aap_pkg::PCT_MIN)) begin
            pct_nxt = '0;
          end else begin
            pct_nxt = PW'(div_quo);
          end
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = pct_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sum_r        <= '0;
      pos_r        <= '0;
      calib_cnt_r  <= '0;
      ref_r        <= '0;
      calibrated_r <= 1'b0;
      swing_r      <= aap_pkg::SWING_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      pos_r        <= pos_nxt;
      calib_cnt_r  <= calib_cnt_nxt;
      ref_r        <= ref_nxt;
      calibrated_r <= calibrated_nxt;
      swing_r      <= swing_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    sample_r  <= sample_nxt;
    mean_r    <= mean_nxt;
    pct_r     <= pct_nxt;
    out_pct_r <= out_pct_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_altitude_percent = out_pct_r;

endmodule

`default_nettype wire

// ===== tb/tb_altitude_average_percent_unit.sv =====
`timescale 1ns / 100ps

// Predicts the altitude percentage for every sample accepted after calibration and holds the
// expected values until the block delivers them.
class altitude_percent_board;
  localparam int DEPTH       = aap_pkg::BUF_DEPTH_DEFAULT;
  localparam int CALIB_ITEMS = aap_pkg::CALIB_FACTOR * DEPTH + 1;

  logic [aap_pkg::SAMPLE_W-1:0] ring_store [DEPTH];
  int unsigned                  window_total;
  int unsigned                  slot;
  int unsigned                  calib_taken;
  int unsigned                  zero_ref;
  bit                           settled;
  logic [aap_pkg::SAMPLE_W-1:0] swing;
  logic [aap_pkg::PCT_W-1:0]    expected_percent [$];

  int n_samples;
  int n_results;
  int n_nonzero;
  int n_err;

  function new();
    foreach (ring_store[i]) ring_store[i] = '0;
    window_total = 0;
    slot         = 0;
    calib_taken  = 0;
    zero_ref     = 0;
    settled      = 1'b0;
    swing        = aap_pkg::SWING_RESET;
    n_samples    = 0;
    n_results    = 0;
    n_nonzero    = 0;
    n_err        = 0;
  endfunction

  function void take_sample(logic [aap_pkg::SAMPLE_W-1:0] s);
    int unsigned mean;
    int unsigned pct;
    n_samples++;
    if (!settled && 32'(s) > zero_ref) zero_ref = 32'(s);
    // Nothing leaves the sum until the ring has been filled once.
    if (settled || calib_taken >= DEPTH) window_total -= 32'(ring_store[slot]);
    window_total += 32'(s);
    ring_store[slot] = s;
    slot = (slot + 1) % DEPTH;
    if (!settled) begin
      calib_taken++;
      if (calib_taken >= CALIB_ITEMS) settled = 1'b1;
      return;
    end
    mean = ((2 * window_total + DEPTH) / 2) / DEPTH;
    if (swing == 0 || mean > zero_ref) begin
      pct = 0;
    end else begin
      pct = (aap_pkg::SCALE * (zero_ref - mean)) / 32'(swing);
      if (pct > aap_pkg::PCT_MAX || pct < aap_pkg::PCT_MIN) pct = 0;
    end
    expected_percent.push_back(pct[aap_pkg::PCT_W-1:0]);
  endfunction

  function void check_percent(logic [aap_pkg::PCT_W-1:0] got);
    logic [aap_pkg::PCT_W-1:0] want;
    if (expected_percent.size() == 0) begin
      $error("altitude_percent: unexpected result, expected none, actual %0d", got);
      n_err++;
      return;
    end
    want = expected_percent.pop_front();
    n_results++;
    if (got != 0) n_nonzero++;
    if (got !== want) begin
      $error("altitude_percent mismatch: expected %0d, actual %0d", want, got);
      n_err++;
    end
  endfunction
endclass

module tb_altitude_average_percent_unit;
  localparam int          LONG_HOLD   = 400;
  localparam int          SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          CALIB_ITEMS = aap_pkg::CALIB_FACTOR * aap_pkg::BUF_DEPTH_DEFAULT + 1;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [aap_pkg::SAMPLE_W-1:0]     in_sample;
  logic                             out_valid;
  logic                             out_stall;
  logic [aap_pkg::PCT_W-1:0]        out_altitude_percent;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [aap_pkg::SAMPLE_W-1:0]     cfg_full_swing;

  altitude_percent_board sb;
  bit                    hold_results = 1'b0;
  bit                    tx_calm      = 1'b0;
  bit                    rx_calm      = 1'b0;
  int                    swing_writes = 0;
  int unsigned           cycle_count  = 0;

  altitude_average_percent_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_altitude_percent (out_altitude_percent),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_full_swing       (cfg_full_swing)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("** altitude_average_percent_unit: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [aap_pkg::SAMPLE_W-1:0] clip_adc(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[aap_pkg::SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_percent(out_altitude_percent);
  end

  initial begin : result_backpressure
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        // A long hold-off lets the output register and the core fill up.
        out_stall    <= 1'b1;
        n            = LONG_HOLD;
        hold_results = 1'b0;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
        n = $urandom_range(20, 150);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        n = idle_cycles();
        if (n == 0) n = 1;
      end
      if ($urandom_range(0, 11) == 0) rx_calm = !rx_calm;
      repeat (n) @(posedge clk);
    end
  end

  // With no gap the request stays valid so that the next call can follow at once.
  task automatic send_sample(input logic [aap_pkg::SAMPLE_W-1:0] s);
    int gap;
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_sample(s);
    gap = tx_calm ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.expected_percent.size() != 0) @(posedge clk);
  endtask

  task automatic change_swing(input logic [aap_pkg::SAMPLE_W-1:0] v);
    wait_results_drained();
    // Calibration samples give no result, so allow the last one to finish.
    repeat (SETTLE) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_full_swing <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.swing = v;
    swing_writes++;
  endtask

  task automatic calibrate();
    int peak;
    int peak_at;
    int k;
    logic [aap_pkg::SAMPLE_W-1:0] s;
    peak    = $urandom_range(2400, 4000);
    peak_at = $urandom_range(40, CALIB_ITEMS - 2);
    for (k = 0; k < CALIB_ITEMS; k++) begin
      if (k == 0) s = '0;
      else if (k == peak_at) s = clip_adc(peak);
      else if (k < 32) s = clip_adc(k * peak / 40);
      else s = clip_adc($urandom_range(peak - 500, peak - 1));
      send_sample(s);
    end
  endtask

  // Full-scale samples push the mean up, zeros pull it down, then come
  // levels at the reference and just below it.
  task automatic directed_edges();
    int k;
    for (k = 0; k < 6; k++) send_sample('1);
    for (k = 0; k < 6; k++) send_sample('0);
    for (k = 0; k < 5; k++) send_sample(clip_adc(int'(sb.zero_ref)));
    for (k = 0; k < 5; k++) send_sample(clip_adc(int'(sb.zero_ref) - 40));
  endtask

  // Runs of samples around a chosen level, with a little noise in between.
  task automatic run_levels(input int count);
    int done;
    int len;
    int centre;
    int spread;
    int swing_view;
    int k;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len && done < count; k++) begin
          send_sample(clip_adc(int'($urandom_range(0, 4095))));
          done++;
        end
      end else begin
        swing_view = (sb.swing == 0) ? 800 : int'(sb.swing);
        centre     = int'(sb.zero_ref) - int'($urandom_range(0, 270)) * swing_view / 100;
        if ($urandom_range(0, 15) == 0)
          centre = int'(sb.zero_ref) + int'($urandom_range(1, 300));
        spread = $urandom_range(0, 40);
        len    = $urandom_range(16, 48);
        for (k = 0; k < len && done < count; k++) begin
          send_sample(clip_adc(centre + int'($urandom_range(0, 2 * spread)) - spread));
          done++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [aap_pkg::SAMPLE_W-1:0] swing_plan [8];
    int i;
    sb = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_sample      <= '0;
    cfg_valid      <= 1'b0;
    cfg_full_swing <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    calibrate();
    directed_edges();
    run_levels(120);
    hold_results = 1'b1;
    run_levels(130);
    wait_results_drained();

    swing_plan[0] = 12'd1;
    swing_plan[1] = 12'd4095;
    swing_plan[2] = 12'd0;
    for (i = 3; i < 7; i++) swing_plan[i] = aap_pkg::SAMPLE_W'($urandom_range(1, 4095));
    swing_plan[7] = aap_pkg::SWING_RESET;
    for (i = 0; i < 8; i++) begin
      change_swing(swing_plan[i]);
      if (i == 0) run_levels(150);
      else if (i == 1) run_levels(200);
      else if (i == 2) run_levels(60);
      else if (i == 7) run_levels(100);
      else run_levels(180);
    end

    wait_results_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d samples, the first %0d of them for calibration (reference %0d).",
             sb.n_samples, CALIB_ITEMS, sb.zero_ref);
    $display("Checked %0d percentages (%0d non-zero) over %0d swing settings; %0d errors.",
             sb.n_results, sb.n_nonzero, swing_writes + 1, sb.n_err);
    if (sb.n_err == 0 && sb.expected_percent.size() == 0) begin
      $display("** altitude_average_percent_unit: PASSED **");
    end else begin
      $display("** altitude_average_percent_unit: FAILED **");
    end
    $finish;
  end
endmodule
